[hw/rtl/dsf_pkg.sv]
// Shared types and constants for the decimal string to binary32 converter.
package dsf_pkg;

  localparam int unsigned MaxLen       = 64;
  localparam int unsigned MaxMantDigits = 9;

  // Numerator scaling for the negative exponent path: m * 2^DivShift / 5^k
  localparam int unsigned DivShift = 152;
  localparam int unsigned XW       = 184;
  localparam int unsigned DW       = 128;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_LONG      = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;

  localparam logic [31:0] INF_BITS = 32'h7f80_0000;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_INT     = 3'd1,
    PH_FRAC    = 3'd2,
    PH_EXPMARK = 3'd3,
    PH_EXPDIG  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    JOB_ERR  = 2'd0,
    JOB_ZERO = 2'd1,
    JOB_INF  = 2'd2,
    JOB_NUM  = 2'd3
  } job_kind_t;

  typedef enum logic [2:0] {
    B_IDLE   = 3'd0,
    B_MUL    = 3'd1,
    B_POW5   = 3'd2,
    B_DIV    = 3'd3,
    B_NORM   = 3'd4,
    B_DENORM = 3'd5,
    B_ROUND  = 3'd6
  } back_state_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       empty_string;
  } dsf_in_t;

  typedef struct packed {
    logic [31:0] float_bits;
    logic [1:0]  status;
  } dsf_out_t;

  typedef struct packed {
    logic [1:0]        status;
    job_kind_t         kind;
    logic              sign;
    logic [29:0]       mant;
    logic signed [7:0] e10;
  } dsf_job_t;

endpackage

[hw/rtl/dsf_fifo.sv]
// Two-entry job queue between the parser and the arithmetic back end.
module dsf_fifo
  import dsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  dsf_job_t wr_data,
  output logic     full,
  input  logic     rd_en,
  output dsf_job_t rd_data,
  output logic     not_empty
);

  dsf_job_t   mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign rd_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

[hw/rtl/dsf_front.sv]
// Character parser: accumulates mantissa and exponent and classifies each string.
module dsf_front
  import dsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dsf_in_t  in_data,
  output logic     job_push,
  output dsf_job_t job_data,
  input  logic     job_full
);

  logic [29:0] mant_r, mant_nxt;
  logic [13:0] exp_r, exp_nxt;
  logic [3:0]  sig_r, sig_nxt;
  logic [2:0]  sige_r, sige_nxt;
  logic [6:0]  frac_r, frac_nxt;
  logic [6:0]  pos_r, pos_nxt;
  phase_t      phase_r, phase_nxt;
  logic        neg_r, neg_nxt;
  logic        nege_r, nege_nxt;
  logic [1:0]  err_r, err_nxt;

  logic              accept;
  logic [7:0]        ch;
  logic              is_digit;
  logic [3:0]        dig;
  logic [29:0]       mant_mul;
  logic [13:0]       exp_mul;
  logic signed [16:0] e10_full;
  logic signed [16:0] mag_sum;
  logic              clear;

  assign in_ready = !job_full;
  assign accept   = in_valid && in_ready;
  assign ch       = in_data.character;
  assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
  assign dig      = ch[3:0];
  assign mant_mul = (mant_r << 3) + (mant_r << 1) + {26'd0, dig};
  assign exp_mul  = (exp_r << 3) + (exp_r << 1) + {10'd0, dig};

  always_comb begin
    mant_nxt  = mant_r;
    exp_nxt   = exp_r;
    sig_nxt   = sig_r;
    sige_nxt  = sige_r;
    frac_nxt  = frac_r;
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    nege_nxt  = nege_r;
    err_nxt   = err_r;
    if (err_r == ST_OK) begin
      if ({25'd0, pos_r} >= MaxLen) begin
        err_nxt = ST_LONG;
      end else begin
        pos_nxt = pos_r + 7'd1;
        case (phase_r)
          PH_START, PH_INT, PH_FRAC: begin
            if (phase_r == PH_START) phase_nxt = PH_INT;
            if (phase_r == PH_START && ch == 8'h2d) begin
              neg_nxt = 1'b1;
            end else if (ch == 8'h2e) begin
              if (phase_r == PH_FRAC) err_nxt = ST_MALFORMED;
              else phase_nxt = PH_FRAC;
            end else if (is_digit) begin
              if ({28'd0, sig_r} >= MaxMantDigits) begin
                err_nxt = ST_LONG;
              end else begin
                mant_nxt = mant_mul;
                if (mant_mul != 30'd0) sig_nxt = sig_r + 4'd1;
                if (phase_r == PH_FRAC) frac_nxt = frac_r + 7'd1;
              end
            end else if (ch == 8'h65 || ch == 8'h45) begin
              phase_nxt = PH_EXPMARK;
            end else begin
              err_nxt = ST_MALFORMED;
            end
          end
          PH_EXPMARK, PH_EXPDIG: begin
            phase_nxt = PH_EXPDIG;
            if (phase_r == PH_EXPMARK && (ch == 8'h2d || ch == 8'h2b)) begin
              nege_nxt = (ch == 8'h2d);
            end else if (!is_digit) begin
              err_nxt = ST_MALFORMED;
            end else if (sige_r > 3'd3) begin
              err_nxt = ST_LONG;
            end else begin
              exp_nxt = exp_mul;
              if (exp_mul != 14'd0) sige_nxt = sige_r + 3'd1;
            end
          end
          default: err_nxt = ST_MALFORMED;
        endcase
      end
    end
  end

  // Classify the finished string from the updated accumulators
  always_comb begin
    e10_full = nege_nxt ? -$signed({3'd0, exp_nxt}) : $signed({3'd0, exp_nxt});
    e10_full = e10_full - $signed({10'd0, frac_nxt});
    mag_sum  = e10_full + $signed({13'd0, sig_nxt});
    job_data.sign   = neg_nxt;
    job_data.mant   = mant_nxt;
    job_data.e10    = e10_full[7:0];
    job_data.status = ST_OK;
    if (in_data.empty_string) begin
      job_data.kind   = JOB_ERR;
      job_data.status = ST_SHORT;
    end else if (err_nxt != ST_OK) begin
      job_data.kind   = JOB_ERR;
      job_data.status = err_nxt;
    end else if (mant_nxt == 30'd0 || mag_sum <= -17'sd46) begin
      job_data.kind = JOB_ZERO;
    end else if (mag_sum >= 17'sd40) begin
      job_data.kind = JOB_INF;
    end else begin
      job_data.kind = JOB_NUM;
    end
  end

  assign clear    = accept && (in_data.empty_string || in_data.last);
  assign job_push = clear;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      mant_r  <= '0;
      exp_r   <= '0;
      sig_r   <= '0;
      sige_r  <= '0;
      frac_r  <= '0;
      pos_r   <= '0;
      phase_r <= PH_START;
      neg_r   <= 1'b0;
      nege_r  <= 1'b0;
      err_r   <= ST_OK;
    end else if (accept) begin
      mant_r  <= mant_nxt;
      exp_r   <= exp_nxt;
      sig_r   <= sig_nxt;
      sige_r  <= sige_nxt;
      frac_r  <= frac_nxt;
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      nege_r  <= nege_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

[hw/rtl/dsf_back.sv]
// Arithmetic back end: scales by powers of ten, normalises and rounds to binary32.
module dsf_back
  import dsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_valid,
  input  dsf_job_t job_data,
  output logic     job_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output dsf_out_t out_data
);

  back_state_t        state_r, state_nxt;
  logic [XW-1:0]      x_r, x_nxt;
  logic [DW-1:0]      d_r, d_nxt;
  logic [DW-1:0]      rem_r, rem_nxt;
  logic [7:0]         cnt_r, cnt_nxt;
  logic signed [11:0] off_r, off_nxt;
  logic               sticky_r, sticky_nxt;
  logic               sign_r, sign_nxt;
  logic               ovalid_r, ovalid_nxt;
  dsf_out_t           odata_r, odata_nxt;

  logic               out_free;
  logic [DW-1:0]      trial;
  logic               ge;
  logic signed [11:0] e2;
  logic signed [11:0] field;
  logic [24:0]        q;
  logic               st;
  logic [23:0]        mant;
  logic               up;
  logic [31:0]        mag;
  logic [7:0]         k;

  assign out_free  = !ovalid_r || out_ready;
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  assign trial = {rem_r[DW-2:0], x_r[XW-1]};
  assign ge    = (trial >= d_r);
  assign e2    = off_r + 12'sd183;
  assign field = e2 + 12'sd126;
  assign q     = x_r[XW-1 -: 25];
  assign st    = sticky_r || (x_r[XW-26:0] != '0);
  assign mant  = q[24:1];
  assign up    = q[0] && (st || mant[0]);
  assign k     = -job_data.e10;

  always_comb begin
    mag = {field[8:0], 23'd0} + {8'd0, mant} + {31'd0, up};
    if (e2 > 12'sd127 || mag >= INF_BITS) mag = INF_BITS;
  end

  always_comb begin
    state_nxt  = state_r;
    x_nxt      = x_r;
    d_nxt      = d_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    off_nxt    = off_r;
    sticky_nxt = sticky_r;
    sign_nxt   = sign_r;
    ovalid_nxt = ovalid_r && !out_ready;
    odata_nxt  = odata_r;
    job_pop    = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          if (job_data.kind == JOB_NUM) begin
            job_pop    = 1'b1;
            sign_nxt   = job_data.sign;
            sticky_nxt = 1'b0;
            if (!job_data.e10[7]) begin
              x_nxt     = {{(XW-30){1'b0}}, job_data.mant};
              cnt_nxt   = job_data.e10;
              off_nxt   = 12'sd0;
              state_nxt = B_MUL;
            end else begin
              d_nxt     = {{(DW-1){1'b0}}, 1'b1};
              cnt_nxt   = k;
              off_nxt   = -12'(DivShift) - $signed({4'd0, k});
              state_nxt = B_POW5;
            end
          end else if (out_free) begin
            job_pop    = 1'b1;
            ovalid_nxt = 1'b1;
            odata_nxt.status = job_data.status;
            case (job_data.kind)
              JOB_ZERO: odata_nxt.float_bits = {job_data.sign, 31'd0};
              JOB_INF:  odata_nxt.float_bits = {job_data.sign, INF_BITS[30:0]};
              default:  odata_nxt.float_bits = 32'd0;
            endcase
          end
        end
      end
      B_MUL: begin
        if (cnt_r == 8'd0) begin
          state_nxt = B_NORM;
        end else begin
          x_nxt   = (x_r << 3) + (x_r << 1);
          cnt_nxt = cnt_r - 8'd1;
        end
      end
      B_POW5: begin
        if (cnt_r == 8'd0) begin
          x_nxt     = {{(XW-30-DivShift){1'b0}}, x_r[29:0], {DivShift{1'b0}}};
          rem_nxt   = '0;
          cnt_nxt   = 8'(XW);
          state_nxt = B_DIV;
        end else begin
          d_nxt   = (d_r << 2) + d_r;
          cnt_nxt = cnt_r - 8'd1;
        end
      end
      B_DIV: begin
        rem_nxt = ge ? (trial - d_r) : trial;
        x_nxt   = {x_r[XW-2:0], ge};
        cnt_nxt = cnt_r - 8'd1;
        if (cnt_r == 8'd1) begin
          sticky_nxt = (rem_nxt != '0);
          state_nxt  = B_NORM;
        end
      end
      B_NORM: begin
        if (x_r[XW-1]) begin
          state_nxt = B_DENORM;
        end else begin
          x_nxt   = x_r << 1;
          off_nxt = off_r - 12'sd1;
        end
      end
      B_DENORM: begin
        // shift right into the subnormal range, collecting lost bits
        if (e2 < -12'sd126) begin
          sticky_nxt = sticky_r || x_r[0];
          x_nxt      = x_r >> 1;
          off_nxt    = off_r + 12'sd1;
        end else begin
          state_nxt = B_ROUND;
        end
      end
      B_ROUND: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt.status     = ST_OK;
          odata_nxt.float_bits = {sign_r, mag[30:0]};
          state_nxt  = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // The negative path keeps the mantissa in x until the divide starts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && job_pop && job_data.e10[7]) begin
      x_r <= {{(XW-30){1'b0}}, job_data.mant};
    end else begin
      x_r <= x_nxt;
    end
    d_r      <= d_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    off_r    <= off_nxt;
    sticky_r <= sticky_nxt;
    sign_r   <= sign_nxt;
    odata_r  <= odata_nxt;
  end

endmodule

[hw/rtl/decimal_string_to_float32_top.sv]
// Result path: after the last character, an error, zero or infinity result passes through the
// job queue to the output register; a number also passes through the iterative back end.
// Back end: e10 >= 0 takes e10 multiply-by-ten steps; e10 < 0 takes -e10 power-of-five
// steps plus 184 restoring-divide steps; normalising takes up to 183 one-bit shifts.
// Throughput: one character per cycle while the two-entry job queue has room.
// Reset: synchronous active-low rst_n clears the parser, the queue and the output valid flag.
module decimal_string_to_float32_top
  import dsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dsf_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output dsf_out_t out_data
);

  logic     push, full, pop, not_empty;
  dsf_job_t push_job, pop_job;

  dsf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .job_push (push),
    .job_data (push_job),
    .job_full (full)
  );

  dsf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (push),
    .wr_data   (push_job),
    .full      (full),
    .rd_en     (pop),
    .rd_data   (pop_job),
    .not_empty (not_empty)
  );

  dsf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (not_empty),
    .job_data  (pop_job),
    .job_pop   (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[tb/sv/dsf_checker.sv]
// Checker for the decimal string converter: predicts each result and compares it.
module dsf_checker
  import dsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  dsf_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  dsf_out_t out_data,
  output int       fail_count,
  output int       results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Parser state, mirrored at the block's widths
  logic [29:0] mant_acc;
  logic [13:0] exp_acc;
  logic [3:0]  mant_sig;
  logic [2:0]  exp_sig;
  logic [6:0]  frac_cnt;
  logic [6:0]  char_cnt;
  phase_t      phase;
  logic        neg_val;
  logic        neg_exp;
  logic [1:0]  err;

  dsf_out_t expected_results[$];

  function automatic logic [31:0] round_binary32(logic [29:0] m, int e10);
    logic [319:0] big;
    logic [24:0]  q;
    logic [23:0]  mant;
    logic [31:0]  bits;
    bit           sticky;
    int           len, e2, lsb, p, k;
    big = '0;
    sticky = 0;
    len = 0;
    if (e10 >= 0) begin
      big = 320'(m) << 160;
      for (int i = 0; i < e10 && i < 64; i++) big = big * 10;
    end else begin
      k = -e10;
      if (k > 100) k = 100;
      big = 320'(m) << (160 - k);
      for (int i = 0; i < k; i++) begin
        if (big % 5 != 0) sticky = 1;
        big = big / 5;
      end
    end
    for (int i = 319; i >= 0; i--) begin
      if (big[i]) begin
        len = i + 1;
        break;
      end
    end
    if (len == 0) return 32'd0;
    e2 = len - 1 - 160;
    if (e2 > 127) return INF_BITS;
    lsb = e2 - 23;
    if (lsb < -149) lsb = -149;
    p = lsb - 1 + 160;
    q = big[p +: 25];
    if ((big & ((320'd1 << p) - 320'd1)) != 0) sticky = 1;
    mant = q[24:1];
    bits = (32'(lsb + 149) << 23) + 32'(mant) + 32'(q[0] && (sticky || mant[0]));
    if (bits >= INF_BITS) bits = INF_BITS;
    return bits;
  endfunction

  function automatic logic [31:0] float_of_string();
    logic [31:0] sign;
    int          e10;
    sign = {neg_val, 31'd0};
    e10 = neg_exp ? -int'(exp_acc) : int'(exp_acc);
    e10 -= int'(frac_cnt);
    if (mant_acc == 0) return sign;
    if (int'(mant_sig) + e10 <= -46) return sign;
    if (int'(mant_sig) + e10 >= 40) return sign | INF_BITS;
    return sign | round_binary32(mant_acc, e10);
  endfunction

  task automatic clear_string();
    mant_acc = '0; exp_acc = '0; mant_sig = '0; exp_sig = '0;
    frac_cnt = '0; char_cnt = '0; phase = PH_START;
    neg_val = 0; neg_exp = 0; err = ST_OK;
  endtask

  task automatic take_mant_char(logic [7:0] ch);
    if (ch == ".") begin
      if (phase == PH_FRAC) err = ST_MALFORMED;
      else phase = PH_FRAC;
    end else if (ch >= "0" && ch <= "9") begin
      if (mant_sig >= MaxMantDigits) begin
        err = ST_LONG;
        return;
      end
      mant_acc = 30'(mant_acc * 10 + 30'(ch - "0"));
      if (mant_acc != 0) mant_sig++;
      if (phase == PH_FRAC) frac_cnt++;
    end else if (ch == "e" || ch == "E") begin
      phase = PH_EXPMARK;
    end else begin
      err = ST_MALFORMED;
    end
  endtask

  task automatic take_exp_char(logic [7:0] ch);
    phase = PH_EXPDIG;
    if (ch < "0" || ch > "9") begin
      err = ST_MALFORMED;
      return;
    end
    if (exp_sig > 3) begin
      err = ST_LONG;
      return;
    end
    exp_acc = 14'(exp_acc * 10 + 14'(ch - "0"));
    if (exp_acc != 0) exp_sig++;
  endtask

  task automatic take_char(logic [7:0] ch);
    case (phase)
      PH_START: begin
        phase = PH_INT;
        if (ch == "-") neg_val = 1;
        else take_mant_char(ch);
      end
      PH_INT, PH_FRAC: take_mant_char(ch);
      PH_EXPMARK: begin
        if (ch == "-" || ch == "+") begin
          neg_exp = (ch == "-");
          phase = PH_EXPDIG;
        end else begin
          take_exp_char(ch);
        end
      end
      PH_EXPDIG: take_exp_char(ch);
      default: err = ST_MALFORMED;
    endcase
  endtask

  task automatic predict_string(dsf_in_t item);
    dsf_out_t res;
    if (item.empty_string) begin
      res.float_bits = '0;
      res.status = ST_SHORT;
      expected_results.push_back(res);
      clear_string();
      return;
    end
    if (err == ST_OK) begin
      if (char_cnt >= MaxLen) begin
        err = ST_LONG;
      end else begin
        char_cnt++;
        take_char(item.character);
      end
    end
    if (!item.last) return;
    if (err != ST_OK) begin
      res.float_bits = '0;
      res.status = err;
    end else begin
      res.float_bits = float_of_string();
      res.status = ST_OK;
    end
    expected_results.push_back(res);
    clear_string();
  endtask

  initial begin
    fail_count = 0;
    clear_string();
  end

  assign results_pending = expected_results.size();

  always @(posedge clk) begin
    dsf_out_t want;
    if (!rst_n) begin
      clear_string();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t unexpected result bits=%h status=%0d", $realtime,
                     out_data.float_bits, out_data.status);
        end else begin
          want = expected_results.pop_front();
          if (want.float_bits !== out_data.float_bits || want.status !== out_data.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t mismatch: expected bits=%h status=%0d, got bits=%h status=%0d",
                       $realtime, want.float_bits, want.status,
                       out_data.float_bits, out_data.status);
          end
        end
      end
      if (in_valid && in_ready) predict_string(in_data);
    end
  end

endmodule

[tb/sv/tb_decimal_string_to_float32_top.sv]
// Testbench top for the decimal string converter: stimulus, flow control and verdict.
module tb_decimal_string_to_float32_top;
  import dsf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk = 0;
  logic     rst_n = 0;
  logic     in_valid = 0;
  logic     in_ready;
  dsf_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 0;
  dsf_out_t out_data;

  int fail_count;
  int results_pending;
  int tx_idle_pct = 37;
  int rx_idle_pct = 73;
  bit hold_request = 0;
  bit hold_done = 0;
  int hold_cycles = 0;
  bit in_fire = 0;
  int chars_sent = 0;

  decimal_string_to_float32_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  dsf_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .results_pending(results_pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) in_fire <= in_valid && in_ready;

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_request && !hold_done) begin
      hold_cycles = 400;
      hold_done = 1;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(logic [7:0] ch, logic last, logic empty);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= '{character: ch, last: last, empty_string: empty};
    do @(negedge clk); while (!in_fire);
    chars_sent++;
  endtask

  task automatic send_string(string s, bit terminate = 1);
    for (int i = 0; i < s.len(); i++)
      send_item(s[i], terminate && (i == s.len() - 1), 0);
  endtask

  task automatic send_empty();
    send_item(8'($urandom), 1'($urandom), 1);
  endtask

  function automatic string digits(int n, bit allow_zero_lead);
    string s;
    s = "";
    for (int i = 0; i < n; i++) begin
      if (i == 0 && !allow_zero_lead) s = {s, string'(8'("1" + $urandom_range(8)))};
      else s = {s, string'(8'("0" + $urandom_range(9)))};
    end
    return s;
  endfunction

  // Number-shaped string with random content, not always well-formed; sizes kept near the interesting ranges
  function automatic string number_string();
    string s;
    int    nint, nfrac;
    s = "";
    if ($urandom_range(1)) s = "-";
    nint = $urandom_range(0, 5);
    nfrac = $urandom_range(0, 5);
    if ($urandom_range(9) == 0) nint = 10;
    s = {s, digits(nint, $urandom_range(3) == 0)};
    if ($urandom_range(1)) s = {s, ".", digits(nfrac, 1)};
    if ($urandom_range(2) != 0) begin
      if ($urandom_range(1)) s = {s, "e"};
      else s = {s, "E"};
      case ($urandom_range(2))
        0: s = {s, "-"};
        1: s = {s, "+"};
        default: ;
      endcase
      if ($urandom_range(5) == 0) s = {s, "00"};
      if ($urandom_range(15) == 0) s = {s, $sformatf("%0d", $urandom_range(10000, 99999))};
      else s = {s, $sformatf("%0d", $urandom_range(0, 50))};
    end
    return s;
  endfunction

  function automatic string noise_string();
    string s;
    s = "";
    for (int i = $urandom_range(1, 6); i > 0; i--) s = {s, string'(8'($urandom))};
    return s;
  endfunction

  task automatic random_strings(int char_budget);
    int stop_at;
    stop_at = chars_sent + char_budget;
    while (chars_sent < stop_at) begin
      case ($urandom_range(19))
        0: send_empty();
        1: begin
          send_string(number_string(), 0);
          send_empty();
        end
        2, 3, 4: send_string(noise_string());
        5: if ($urandom_range(3) == 0) send_string({"1.", digits(70, 1)});
        default: send_string(number_string());
      endcase
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed strings
    send_empty();
    send_string("0");
    send_string("-");
    send_string("-0.000");
    send_string("123.45");
    send_string("1e10");
    send_string("-1E-10");
    send_string("3.4028235e38");
    send_string("3.4028236e38");
    send_string("1e39");
    send_string("1e-46");
    send_string("1e-47");
    send_string("7.00649e-46");
    send_string("1.4e-45");
    send_string(".5");
    send_string("1..2");
    send_string("1e-+5");
    send_string("1e5.");
    send_string("12x34");
    send_string("1234567890");
    send_string("00000000001234");
    send_string("1e00012345");
    send_string({"0.", digits(70, 1)});
    send_string("-1-");
    send_string("e");
    send_string("7\xff");
    send_string("12", 0);
    send_empty();

    random_strings(110);
    tx_idle_pct = 73;
    rx_idle_pct = 37;
    random_strings(110);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = 1;
    random_strings(100);
    in_valid <= 0;

    while (results_pending != 0) @(negedge clk);
    repeat (500) @(negedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
